/* hdl/rmxt_pkg.sv */
// package for the range max-xor persistent trie block
// sizes, item and result types, state machine codes, controller/datapath links
// no dependencies
package rmxt_pkg;

  localparam int MAX_ITEMS  = 4096;
  localparam int VALUE_BITS = 24;
  localparam int NODE_COUNT = 131072;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int IDX_W  = $clog2(MAX_ITEMS + 1);
  localparam int LAT_W  = IDX_W;
  localparam int NF_W   = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = $clog2(VALUE_BITS);
  localparam int PS_DEPTH = MAX_ITEMS + 1;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_ANSWERED = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef struct packed {
    logic                  op;
    logic [VALUE_BITS-1:0] value;
    logic [12:0]           range_left;
    logic [12:0]           range_right;
  } item_in_t;

  typedef struct packed {
    logic [23:0] answer;
    logic [1:0]  status;
  } item_out_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_BLD_START,
    S_BLD_LVL,
    S_BLD_LEAF,
    S_Q_ROOT,
    S_Q_LOAD,
    S_Q_LT,
    S_Q_SEL,
    S_Q_IDX,
    S_Q_ANS
  } state_t;

  typedef struct packed {
    logic    latch_item;
    logic    init;
    logic    bld_start;
    logic    bld_level;
    logic    bld_leaf;
    logic    q_root;
    logic    q_load;
    logic    q_lt;
    logic    q_sel;
    logic    q_idx;
    logic    emit;
    status_t emit_status;
  } rmxt_cmd_t;

  typedef struct packed {
    logic is_query;
    logic full;
    logic bad_range;
    logic last_level;
  } rmxt_sts_t;

endpackage

/* hdl/rmxt_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rmxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/rmxt_datapath.sv */
// datapath: trie memories, prefix and root stores, walk registers, result register
// depends on rmxt_pkg and rmxt_ram
module rmxt_datapath
  import rmxt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  item_in_t  item,
  input  rmxt_cmd_t cmd,
  output rmxt_sts_t sts,
  output item_out_t result,
  output logic      done
);

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(VALUE_BITS - 1);
  localparam logic [NF_W-1:0]  NF_LIMIT = NF_W'(NODE_COUNT - VALUE_BITS - 1);
  localparam logic [NF_W-1:0]  NF_STEP  = NF_W'(VALUE_BITS + 1);

  item_in_t              item_r;
  logic [IDX_W-1:0]      count;
  logic [NF_W-1:0]       next_free;
  logic [VALUE_BITS-1:0] last_prefix;
  logic [NODE_W-1:0]     last_root;
  logic [NODE_W-1:0]     q;
  logic [NODE_W-1:0]     root;
  logic [LVL_W-1:0]      lvl;
  logic [IDX_W-1:0]      bidx;
  logic [VALUE_BITS-1:0] bval;
  logic [VALUE_BITS-1:0] val;
  logic [NODE_W-1:0]     other_r;
  logic [NODE_W-1:0]     same_r;
  logic                  ch_zero;
  logic                  lt_zero;

  logic                  ch_we;
  logic [NODE_W-1:0]     ch_waddr, ch_raddr;
  logic [NODE_W-1:0]     cz_wdata, co_wdata, cz_rdata, co_rdata;
  logic                  lt_we;
  logic [NODE_W-1:0]     lt_raddr;
  logic [LAT_W-1:0]      lt_rdata;
  logic                  ps_we;
  logic [IDX_W-1:0]      ps_raddr;
  logic [VALUE_BITS-1:0] ps_rdata;
  logic [NODE_W-1:0]     vr_rdata;

  logic [IDX_W-1:0]      bidx_c;
  logic [VALUE_BITS-1:0] bval_c;
  logic [NODE_W-1:0]     cz_d, co_d;
  logic [LAT_W-1:0]      lt_d;
  logic                  bit_b, bit_q;
  logic [LVL_W-1:0]      bit_sel;
  logic [NODE_W-1:0]     q_plus;
  logic [NODE_W-1:0]     now_next;
  logic [IDX_W-1:0]      end_idx;

  assign cz_d    = ch_zero ? '0 : cz_rdata;
  assign co_d    = ch_zero ? '0 : co_rdata;
  assign lt_d    = lt_zero ? '0 : lt_rdata;
  assign bit_sel = LVL_TOP - lvl;
  assign bit_b   = bval[bit_sel];
  assign bit_q   = val[bit_sel];
  assign q_plus  = q + NODE_W'(1);
  assign bidx_c  = cmd.init ? '0 : count + IDX_W'(1);
  assign bval_c  = cmd.init ? '0 : last_prefix ^ item_r.value;
  assign now_next = (lt_d >= item_r.range_left) ? other_r : same_r;
  assign end_idx  = (lt_d != '0) ? lt_d - LAT_W'(1) : '0;

  always_comb begin
    ch_we    = 1'b0;
    ch_waddr = q;
    cz_wdata = '0;
    co_wdata = '0;
    ch_raddr = '0;
    lt_we    = 1'b0;
    lt_raddr = '0;
    ps_we    = 1'b0;
    ps_raddr = end_idx;
    if (cmd.bld_start) begin
      ps_we    = 1'b1;
      ch_raddr = cmd.init ? '0 : last_root;
    end
    if (cmd.bld_level) begin
      ch_we    = 1'b1;
      lt_we    = 1'b1;
      cz_wdata = bit_b ? cz_d : q_plus;
      co_wdata = bit_b ? q_plus : co_d;
      ch_raddr = bit_b ? co_d : cz_d;
    end
    if (cmd.bld_leaf) begin
      ch_we = 1'b1;
      lt_we = 1'b1;
    end
    if (cmd.q_load) begin
      ch_raddr = vr_rdata;
    end
    if (cmd.q_lt) begin
      lt_raddr = bit_q ? cz_d : co_d;
    end
    if (cmd.q_sel) begin
      ch_raddr = now_next;
      lt_raddr = now_next;
    end
  end

  rmxt_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_child_zero (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(cz_wdata),
    .raddr(ch_raddr), .rdata(cz_rdata)
  );

  rmxt_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_child_one (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(co_wdata),
    .raddr(ch_raddr), .rdata(co_rdata)
  );

  rmxt_ram #(.WIDTH(LAT_W), .DEPTH(NODE_COUNT)) u_latest (
    .clk(clk), .we(lt_we), .waddr(q), .wdata(bidx + LAT_W'(1)),
    .raddr(lt_raddr), .rdata(lt_rdata)
  );

  rmxt_ram #(.WIDTH(VALUE_BITS), .DEPTH(PS_DEPTH)) u_prefix (
    .clk(clk), .we(ps_we), .waddr(bidx_c), .wdata(bval_c),
    .raddr(ps_raddr), .rdata(ps_rdata)
  );

  rmxt_ram #(.WIDTH(NODE_W), .DEPTH(PS_DEPTH)) u_roots (
    .clk(clk), .we(ps_we), .waddr(bidx_c), .wdata(NODE_W'(next_free)),
    .raddr(item_r.range_right - IDX_W'(1)), .rdata(vr_rdata)
  );

  always_ff @(posedge clk) begin
    ch_zero <= (ch_raddr == '0);
    lt_zero <= (lt_raddr == '0);
    if (cmd.latch_item) begin
      item_r <= item;
    end
    if (cmd.bld_start) begin
      bidx <= bidx_c;
      bval <= bval_c;
      q    <= NODE_W'(next_free);
      root <= NODE_W'(next_free);
      lvl  <= '0;
    end
    if (cmd.bld_level) begin
      q   <= q_plus;
      lvl <= lvl + LVL_W'(1);
    end
    if (cmd.q_root) begin
      val <= item_r.value ^ last_prefix;
    end
    if (cmd.q_load) begin
      lvl <= '0;
    end
    if (cmd.q_lt) begin
      other_r <= bit_q ? cz_d : co_d;
      same_r  <= bit_q ? co_d : cz_d;
    end
    if (cmd.q_sel) begin
      lvl <= lvl + LVL_W'(1);
    end
    if (cmd.emit) begin
      result.status <= cmd.emit_status;
      result.answer <= (cmd.emit_status == ST_ANSWERED) ? (ps_rdata ^ val) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      next_free   <= NF_W'(1);
      last_prefix <= '0;
      last_root   <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.bld_leaf) begin
        count       <= bidx;
        next_free   <= next_free + NF_STEP;
        last_prefix <= bval;
        last_root   <= root;
      end
    end
  end

  assign sts.is_query   = (item_r.op == OP_QUERY);
  assign sts.full       = (count >= IDX_W'(MAX_ITEMS)) || (next_free > NF_LIMIT);
  assign sts.bad_range  = (item_r.range_left == '0) ||
                          (item_r.range_left > item_r.range_right) ||
                          (item_r.range_right > count);
  assign sts.last_level = (lvl == LVL_TOP);

endmodule

/* hdl/rmxt_ctrl.sv */
// controller state machine: sequences trie builds, query walks and results
// depends on rmxt_pkg
module rmxt_ctrl
  import rmxt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  rmxt_sts_t sts,
  output rmxt_cmd_t cmd,
  output logic      busy
);

  state_t state, state_next;
  logic   booted, booted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      booted <= 1'b0;
    end else begin
      state  <= state_next;
      booted <= booted_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    booted_next = booted;
    cmd         = '0;
    unique case (state)
      S_INIT: begin
        cmd.bld_start = 1'b1;
        cmd.init      = 1'b1;
        state_next    = S_BLD_LVL;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_item = 1'b1;
          state_next     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.is_query) begin
          if (sts.full) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_FULL;
            state_next      = S_IDLE;
          end else begin
            state_next = S_BLD_START;
          end
        end else if (sts.bad_range) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_BAD;
          state_next      = S_IDLE;
        end else begin
          state_next = S_Q_ROOT;
        end
      end
      S_BLD_START: begin
        cmd.bld_start = 1'b1;
        state_next    = S_BLD_LVL;
      end
      S_BLD_LVL: begin
        cmd.bld_level = 1'b1;
        if (sts.last_level) begin
          state_next = S_BLD_LEAF;
        end
      end
      S_BLD_LEAF: begin
        cmd.bld_leaf    = 1'b1;
        cmd.emit        = booted;
        cmd.emit_status = ST_APPENDED;
        booted_next     = 1'b1;
        state_next      = S_IDLE;
      end
      S_Q_ROOT: begin
        cmd.q_root = 1'b1;
        state_next = S_Q_LOAD;
      end
      S_Q_LOAD: begin
        cmd.q_load = 1'b1;
        state_next = S_Q_LT;
      end
      S_Q_LT: begin
        cmd.q_lt   = 1'b1;
        state_next = S_Q_SEL;
      end
      S_Q_SEL: begin
        cmd.q_sel  = 1'b1;
        state_next = sts.last_level ? S_Q_IDX : S_Q_LT;
      end
      S_Q_IDX: begin
        cmd.q_idx  = 1'b1;
        state_next = S_Q_ANS;
      end
      S_Q_ANS: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_ANSWERED;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/range_max_xor_persistent_trie.sv */
// Range max-xor over a persistent binary trie of 24-bit prefix xors. An item is
// taken when start is high and busy is low; its one result appears on result
// with done high for a single cycle and cannot be held off. An append builds one
// trie level per cycle (one child-memory access each); a query walks each level
// as a child read, then a latest-index read; a full store or bad range is
// answered from the decide state without a walk. After reset the block is busy
// while it builds version zero.
// depends on rmxt_pkg, rmxt_ctrl, rmxt_datapath
module range_max_xor_persistent_trie
  import rmxt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  item_in_t  item,
  output item_out_t result,
  output logic      done
);

  rmxt_cmd_t cmd;
  rmxt_sts_t sts;

  rmxt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  rmxt_datapath u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .sts(sts),
    .result(result), .done(done)
  );

endmodule

/* hdl/rmxt_checker.sv */
// port-level checker for the range max-xor trie block, bound to the top level
// depends on rmxt_pkg
module rmxt_checker
  import rmxt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input item_out_t result,
  input logic      done
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in progress");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("more than one result for an item");

  a_answer_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_ANSWERED) |-> result.answer == '0)
    else $error("nonzero answer on a non-query result");

endmodule

bind range_max_xor_persistent_trie rmxt_checker u_rmxt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result(result), .done(done)
);

/* verif/range_max_xor_persistent_trie_test.sv */
// testbench for range_max_xor_persistent_trie: directed table, then random appends and queries
// results are checked against a behavioral persistent-trie max-xor predictor
// depends on rmxt_pkg and the range_max_xor_persistent_trie rtl
module range_max_xor_persistent_trie_test;
  import rmxt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  item_in_t item = '0;
  item_out_t result;

  range_max_xor_persistent_trie dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .result(result), .done(done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: persistent trie over prefix xors
  logic [23:0] pfx_xor [0:MAX_ITEMS];
  logic [16:0] root_of [0:MAX_ITEMS];
  logic [16:0] kid0 [0:NODE_COUNT-1];
  logic [16:0] kid1 [0:NODE_COUNT-1];
  logic [12:0] newest [0:NODE_COUNT-1];
  int free_node;
  int appended;

  item_out_t answers_due [$];
  int errors = 0;
  int n_app = 0, n_qry = 0, n_full = 0, n_bad = 0;
  int send_idle = 0;

  function automatic void grow_version(int ver, int prev);
    int path [0:23];
    logic [23:0] v;
    int q, p, nn, a, b;
    v = pfx_xor[ver];
    q = free_node++;
    p = prev;
    root_of[ver] = 17'(q);
    for (int lvl = 0; lvl < 24; lvl++) begin
      nn = free_node++;
      path[lvl] = q;
      if (v[23-lvl]) begin
        kid1[q] = 17'(nn); kid0[q] = kid0[p]; p = int'(kid1[p]);
      end else begin
        kid0[q] = 17'(nn); kid1[q] = kid1[p]; p = int'(kid0[p]);
      end
      q = nn;
    end
    kid0[q] = '0; kid1[q] = '0;
    newest[q] = 13'(ver + 1);
    for (int lvl = 23; lvl >= 0; lvl--) begin
      a = int'(newest[kid0[path[lvl]]]);
      b = int'(newest[kid1[path[lvl]]]);
      newest[path[lvl]] = 13'(a > b ? a : b);
    end
  endfunction

  function automatic void trie_clear();
    kid0[0] = '0; kid1[0] = '0; newest[0] = '0;
    pfx_xor[0] = '0;
    appended = 0;
    free_node = 1;
    grow_version(0, 0);
  endfunction

  function automatic item_out_t trie_apply(item_in_t it);
    item_out_t r;
    int now, l, rr, idx;
    logic [23:0] val;
    logic c;
    int other;
    r = '0;
    l = int'(it.range_left);
    rr = int'(it.range_right);
    if (it.op == OP_APPEND) begin
      if (appended >= MAX_ITEMS || free_node > NODE_COUNT - 25) begin
        r.status = ST_FULL;
      end else begin
        pfx_xor[appended+1] = pfx_xor[appended] ^ it.value;
        grow_version(appended + 1, int'(root_of[appended]));
        appended++;
        r.status = ST_APPENDED;
      end
    end else if (l == 0 || l > rr || rr > appended) begin
      r.status = ST_BAD;
    end else begin
      now = int'(root_of[rr-1]);
      val = it.value ^ pfx_xor[appended];
      for (int k = 23; k >= 0; k--) begin
        c = val[k];
        other = c ? int'(kid0[now]) : int'(kid1[now]);
        if (int'(newest[other]) >= l) now = other;
        else now = c ? int'(kid1[now]) : int'(kid0[now]);
      end
      idx = (newest[now] != '0) ? int'(newest[now]) - 1 : 0;
      r.answer = pfx_xor[idx] ^ val;
      r.status = ST_ANSWERED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    item_out_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result answer=%h status=%0d", $time,
                 result.answer, result.status);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (result.answer !== want.answer || result.status !== want.status) begin
          $display("%0t: mismatch expected answer=%h status=%0d actual answer=%h status=%0d",
                   $time, want.answer, want.status, result.answer, result.status);
          errors++;
        end
        case (want.status)
          ST_APPENDED: n_app++;
          ST_ANSWERED: n_qry++;
          ST_FULL:     n_full++;
          default:     n_bad++;
        endcase
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("range_max_xor_persistent_trie_test: FAIL");
      $finish;
    end
  end

  task automatic issue(item_in_t it, logic use_typed, item_out_t typed);
    item_out_t p;
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = trie_apply(it);
    if (use_typed && p !== typed) begin
      $display("%0t: table row expected answer=%h status=%0d predictor=%h status=%0d",
               $time, typed.answer, typed.status, p.answer, p.status);
      errors++;
    end
    answers_due.push_back(p);
  endtask

  function automatic item_in_t mk(op_t op, logic [23:0] v, logic [12:0] l, logic [12:0] r);
    item_in_t it;
    it.op = op; it.value = v; it.range_left = l; it.range_right = r;
    return it;
  endfunction

  function automatic item_out_t res(logic [23:0] a, status_t s);
    item_out_t o;
    o.answer = a; o.status = s;
    return o;
  endfunction

  typedef struct {
    item_in_t stim;
    logic typed;
    item_out_t want;
  } row_t;

  row_t rows [$];

  task automatic random_phase(int count);
    item_in_t it;
    int l, r;
    for (int i = 0; i < count; i++) begin
      it.value = 24'($urandom());
      if ($urandom_range(99) < 3) it.value = {24{1'($urandom_range(1))}};
      if ($urandom_range(99) < 45 && appended < MAX_ITEMS) begin
        it.op = OP_APPEND;
        it.range_left = 13'($urandom()); it.range_right = 13'($urandom());
      end else begin
        it.op = OP_QUERY;
        if ($urandom_range(99) < 88 && appended > 0) begin
          r = $urandom_range(appended, 1);
          l = $urandom_range(99) < 20 ? r : $urandom_range(r, 1);
          if ($urandom_range(9) == 0) l = 1;
        end else begin
          r = $urandom_range(8191);
          l = $urandom_range(8191);
        end
        it.range_left = 13'(l); it.range_right = 13'(r);
      end
      issue(it, 1'b0, '0);
    end
  endtask

  initial begin
    trie_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{mk(OP_QUERY, 24'h0, 13'd1, 13'd1), 1'b1, res(24'h0, ST_BAD)});
    rows.push_back('{mk(OP_QUERY, 24'hFFFFFF, 13'd0, 13'd0), 1'b1, res(24'h0, ST_BAD)});
    rows.push_back('{mk(OP_APPEND, 24'hFFFFFF, 13'd0, 13'd0), 1'b1,
                     res(24'h0, ST_APPENDED)});
    rows.push_back('{mk(OP_QUERY, 24'h0, 13'd1, 13'd1), 1'b1,
                     res(24'hFFFFFF, ST_ANSWERED)});
    rows.push_back('{mk(OP_QUERY, 24'hFFFFFF, 13'd1, 13'd1), 1'b1,
                     res(24'h0, ST_ANSWERED)});
    rows.push_back('{mk(OP_APPEND, 24'h000000, 13'h1FFF, 13'h1FFF), 1'b1,
                     res(24'h0, ST_APPENDED)});
    rows.push_back('{mk(OP_APPEND, 24'hA5A5A5, 13'd0, 13'd0), 1'b0, '0});
    rows.push_back('{mk(OP_APPEND, 24'h5A5A5A, 13'd0, 13'd0), 1'b0, '0});
    rows.push_back('{mk(OP_QUERY, 24'h123456, 13'd1, 13'd4), 1'b0, '0});
    rows.push_back('{mk(OP_QUERY, 24'h800001, 13'd2, 13'd3), 1'b0, '0});
    rows.push_back('{mk(OP_QUERY, 24'h7FFFFE, 13'd4, 13'd4), 1'b0, '0});
    rows.push_back('{mk(OP_QUERY, 24'h0, 13'd0, 13'd2), 1'b1, res(24'h0, ST_BAD)});
    rows.push_back('{mk(OP_QUERY, 24'h0, 13'd3, 13'd2), 1'b1, res(24'h0, ST_BAD)});
    rows.push_back('{mk(OP_QUERY, 24'h0, 13'd1, 13'd5), 1'b1, res(24'h0, ST_BAD)});
    rows.push_back('{mk(OP_QUERY, 24'hFFFFFF, 13'h1FFF, 13'h1FFF), 1'b1,
                     res(24'h0, ST_BAD)});
    rows.push_back('{mk(OP_QUERY, 24'h0, 13'd4096, 13'd4096), 1'b1, res(24'h0, ST_BAD)});
    foreach (rows[i]) issue(rows[i].stim, rows[i].typed, rows[i].want);

    send_idle = 21;
    random_phase(500);
    send_idle = 47;
    random_phase(500);
    send_idle = 0;
    random_phase(500);

    // queries at the top end of the index range
    issue(mk(OP_QUERY, 24'hFFFFFF, 13'd1, 13'(appended)), 1'b0, '0);
    issue(mk(OP_QUERY, 24'h0, 13'd1, 13'd4097), 1'b1, res(24'h0, ST_BAD));
    random_phase(30);
    start <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d appends, %0d answered queries, %0d full, %0d bad range",
             n_app, n_qry, n_full, n_bad);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("range_max_xor_persistent_trie_test: PASS");
    end else begin
      $display("range_max_xor_persistent_trie_test: FAIL");
    end
    $finish;
  end

endmodule
